/* hw/rtl/ufr_pkg.sv */
// Shared types and constants for the UDP fragment reassembler.
package ufr_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FINISH,
		ST_LOOKUP,
		ST_DECIDE,
		ST_COPY_STG,
		ST_COPY_ENT,
		ST_RESULT
	} state_t;

	// Copy source and destination selection.
	typedef enum logic [1:0] {
		CP_STG_TO_OUT,
		CP_STG_TO_ENT,
		CP_ENT_TO_OUT
	} copy_t;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam int MSGNUM_LSB = 4;
	localparam int SIZE_LSB   = 8;
	localparam int FIELD_BYTES = 4;

	typedef struct packed {
		logic take_byte;
		logic clear_header;
		logic scan_start;
		logic copy_start;
		copy_t copy_kind;
		logic drain;
		logic commit_alloc;
		logic commit_restart;
		logic commit_append;
		logic commit_emit_direct;
		logic bump_drop;
		logic bump_loss;
	} cmd_t;

	typedef enum logic [2:0] {
		DEC_NONE,
		DEC_DROP,
		DEC_DIRECT,
		DEC_ALLOC,
		DEC_RESTART,
		DEC_APPEND,
		DEC_APPEND_EMIT
	} decision_t;

	typedef struct packed {
		logic scan_done;
		logic copy_done;
		decision_t decision;
	} status_t;

endpackage

/* hw/rtl/udp_fragment_reassembler.sv */
// Top level of the UDP fragment reassembler.
// Datagram bytes (command 0) are taken one per cycle while the block is
// idle and no result is pending. The byte flagged end_of_datagram starts
// the finish sequence: a table scan of SENDER_ENTRIES entries, a decision
// state, then for each buffer copy (payload to entry or output, and entry
// to output when a message completes) one byte a cycle through a registered
// memory read, and a closing state; during that time no transfer is taken.
// A drain step (command 1) yields one result transfer; the next input
// transfer is taken once that result has been taken. The counters are
// reported on every result.
module udp_fragment_reassembler #(
	parameter int HEADER_BYTES = 12,
	parameter int SENDER_ENTRIES = 8,
	parameter int MAX_MESSAGE_BYTES = 2048
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic command,
	input  logic [7:0] data_byte,
	input  logic end_of_datagram,
	output logic res_valid,
	input  logic res_ready,
	output logic out_valid,
	output logic [7:0] out_byte,
	output logic out_last,
	output logic [15:0] lost_count,
	output logic [15:0] dropped_count
);
	ufr_pkg::cmd_t cmd;
	ufr_pkg::status_t status;

	ufr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .end_of_datagram(end_of_datagram),
		.out_ready_hold(res_valid), .out_ready(res_ready),
		.status(status), .cmd(cmd)
	);

	ufr_datapath #(
		.HDR(HEADER_BYTES), .ENT(SENDER_ENTRIES), .MAXB(MAX_MESSAGE_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(data_byte),
		.status(status), .out_valid(out_valid), .out_byte(out_byte),
		.out_last(out_last), .lost_count(lost_count),
		.dropped_count(dropped_count)
	);
endmodule

/* hw/rtl/ufr_datapath.sv */
// Datapath: header capture, staging, sender table, output buffer, counters.
module ufr_datapath #(
	parameter int HDR = 12,
	parameter int ENT = 8,
	parameter int MAXB = 2048
) (
	input  logic clk,
	input  logic arst_n,
	input  ufr_pkg::cmd_t cmd,
	input  logic [7:0] data_byte,
	output ufr_pkg::status_t status,
	output logic out_valid,
	output logic [7:0] out_byte,
	output logic out_last,
	output logic [15:0] lost_count,
	output logic [15:0] dropped_count
);
	localparam int PW = $clog2(HDR + MAXB + 2);
	localparam int LW = $clog2(MAXB + 1);
	localparam int AW = (MAXB > 1) ? $clog2(MAXB) : 1;
	localparam int EW = (ENT > 1) ? $clog2(ENT) : 1;
	localparam int SW = $clog2(ENT + 1);
	localparam logic [PW-1:0] POS_LIMIT = PW'(HDR + MAXB + 1);

	logic [PW-1:0] pos_q;
	logic [31:0] sender_q, msgnum_q, size_q;
	logic [7:0] stg_mem [MAXB];
	// one region of 2**AW bytes per entry
	logic [7:0] ent_mem [ENT * (1 << AW)];
	logic [7:0] out_mem [MAXB];
	logic [ENT-1:0] valid_q;
	logic [31:0] esender_q [ENT];
	logic [31:0] enum_q [ENT];
	logic [LW-1:0] elen_q [ENT];
	logic [LW-1:0] olen_q, ordpos_q;
	logic [15:0] loss_q, drop_q;

	// Sender scan.
	logic [SW-1:0] scan_q;
	logic found_q, free_found_q;
	logic [EW-1:0] slot_q, free_q;
	logic scan_done;

	// Copy engine.
	logic [LW-1:0] cp_cnt_q, cp_len_q, cp_dst_off_q;
	logic cp_run_q, cp_rd_s1, cp_last_s1;
	logic [LW-1:0] cp_idx_s1;
	ufr_pkg::copy_t cp_kind_q;
	logic [7:0] stg_rd_s1, ent_rd_s1;

	logic [7:0] out_rd_q;
	logic [PW-1:0] plen_full;
	logic [LW-1:0] plen;
	logic [LW:0] total;
	logic [EW+AW-1:0] ent_base;

	assign plen_full = pos_q - PW'(HDR);
	assign plen = plen_full[LW-1:0];
	assign total = {1'b0, elen_q[slot_q]} + {1'b0, plen};
	assign scan_done = (scan_q == SW'(ENT));
	assign ent_base = {slot_q, {AW{1'b0}}};

	// Header capture and byte counting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sender_q <= '0;
			msgnum_q <= '0;
			size_q <= '0;
		end else if (cmd.clear_header) begin
			pos_q <= '0;
			sender_q <= '0;
			msgnum_q <= '0;
			size_q <= '0;
		end else if (cmd.take_byte) begin
			if (pos_q < PW'(ufr_pkg::MSGNUM_LSB))
				sender_q[8*pos_q[1:0] +: 8] <= data_byte;
			else if (pos_q < PW'(ufr_pkg::SIZE_LSB))
				msgnum_q[8*pos_q[1:0] +: 8] <= data_byte;
			else if (pos_q < PW'(ufr_pkg::SIZE_LSB + ufr_pkg::FIELD_BYTES))
				size_q[8*pos_q[1:0] +: 8] <= data_byte;
			if (pos_q < POS_LIMIT)
				pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte && pos_q >= PW'(HDR) && plen_full < PW'(MAXB))
			stg_mem[plen_full[AW-1:0]] <= data_byte;
	end

	// Scan the table one entry a cycle for a matching or free entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= SW'(ENT);
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			slot_q <= '0;
			free_q <= '0;
		end else if (cmd.scan_start) begin
			scan_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (!scan_done) begin
			scan_q <= scan_q + 1'b1;
			if (!found_q && valid_q[scan_q[EW-1:0]] &&
			    esender_q[scan_q[EW-1:0]] == sender_q) begin
				found_q <= 1'b1;
				slot_q <= scan_q[EW-1:0];
			end
			if (!free_found_q && !valid_q[scan_q[EW-1:0]]) begin
				free_found_q <= 1'b1;
				free_q <= scan_q[EW-1:0];
			end
		end else if (!found_q && free_found_q && cmd.commit_alloc) begin
			slot_q <= free_q;
		end
	end

	// Decision, valid once the header is complete and the scan is done.
	always_comb begin
		status.decision = ufr_pkg::DEC_NONE;
		if (pos_q <= PW'(HDR))
			status.decision = ufr_pkg::DEC_NONE;
		else if (plen_full > PW'(MAXB))
			status.decision = ufr_pkg::DEC_DROP;
		else if ({{(32-LW){1'b0}}, plen} == size_q)
			status.decision = (olen_q != '0) ? ufr_pkg::DEC_DROP : ufr_pkg::DEC_DIRECT;
		else if (!found_q)
			status.decision = free_found_q ? ufr_pkg::DEC_ALLOC : ufr_pkg::DEC_DROP;
		else if (elen_q[slot_q] != '0 && enum_q[slot_q] != msgnum_q)
			status.decision = ufr_pkg::DEC_RESTART;
		else if (total > (LW+1)'(MAXB))
			status.decision = ufr_pkg::DEC_DROP;
		else if ({{(31-LW){1'b0}}, total} == size_q)
			status.decision = (olen_q != '0) ? ufr_pkg::DEC_DROP
			                                 : ufr_pkg::DEC_APPEND_EMIT;
		else
			status.decision = ufr_pkg::DEC_APPEND;
	end
	assign status.scan_done = scan_done;
	assign status.copy_done = !cp_run_q && !cp_rd_s1;

	// Table updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < ENT; i++)
				elen_q[i] <= '0;
		end else begin
			if (cmd.commit_alloc) begin
				valid_q[free_q] <= 1'b1;
				elen_q[free_q] <= plen;
			end
			if (cmd.commit_restart)
				elen_q[slot_q] <= plen;
			if (cmd.commit_append)
				elen_q[slot_q] <= total[LW-1:0];
			if (cp_rd_s1 && cp_last_s1 && cp_kind_q == ufr_pkg::CP_ENT_TO_OUT)
				elen_q[slot_q] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_alloc) begin
			esender_q[free_q] <= sender_q;
			enum_q[free_q] <= msgnum_q;
		end
		if (cmd.commit_restart || cmd.commit_append)
			enum_q[slot_q] <= msgnum_q;
	end

	// Copy engine: one byte a cycle, read registered, then written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_run_q <= 1'b0;
			cp_rd_s1 <= 1'b0;
			cp_cnt_q <= '0;
			cp_len_q <= '0;
			cp_dst_off_q <= '0;
			cp_kind_q <= ufr_pkg::CP_STG_TO_OUT;
		end else begin
			cp_rd_s1 <= cp_run_q;
			if (cmd.copy_start) begin
				cp_kind_q <= cmd.copy_kind;
				cp_cnt_q <= '0;
				if (cmd.copy_kind == ufr_pkg::CP_ENT_TO_OUT) begin
					cp_len_q <= elen_q[slot_q];
					cp_dst_off_q <= '0;
				end else begin
					cp_len_q <= plen;
					cp_dst_off_q <= cmd.commit_append ? elen_q[slot_q] : '0;
				end
				cp_run_q <= 1'b1;
			end else if (cp_run_q) begin
				cp_cnt_q <= cp_cnt_q + 1'b1;
				if (cp_cnt_q + 1'b1 == cp_len_q)
					cp_run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cp_idx_s1 <= cp_cnt_q;
		cp_last_s1 <= (cp_cnt_q + 1'b1 == cp_len_q);
		stg_rd_s1 <= stg_mem[cp_cnt_q[AW-1:0]];
		ent_rd_s1 <= ent_mem[ent_base + (EW+AW)'(cp_cnt_q[AW-1:0])];
		if (cp_rd_s1) begin
			if (cp_kind_q == ufr_pkg::CP_STG_TO_ENT)
				ent_mem[ent_base + (EW+AW)'(cp_idx_s1 + cp_dst_off_q)] <= stg_rd_s1;
			else if (cp_kind_q == ufr_pkg::CP_STG_TO_OUT)
				out_mem[cp_idx_s1[AW-1:0]] <= stg_rd_s1;
			else
				out_mem[cp_idx_s1[AW-1:0]] <= ent_rd_s1;
		end
		out_rd_q <= out_mem[ordpos_q[AW-1:0]];
	end

	// Output buffer and drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olen_q <= '0;
			ordpos_q <= '0;
			out_valid <= 1'b0;
			out_last <= 1'b0;
			out_byte <= '0;
		end else begin
			if (cmd.commit_emit_direct) begin
				olen_q <= plen;
				ordpos_q <= '0;
			end
			if (cp_rd_s1 && cp_last_s1 && cp_kind_q == ufr_pkg::CP_ENT_TO_OUT) begin
				olen_q <= elen_q[slot_q];
				ordpos_q <= '0;
			end
			if (cmd.drain) begin
				if (olen_q != '0 && ordpos_q < olen_q) begin
					out_valid <= 1'b1;
					out_byte <= out_rd_q;
					if (ordpos_q + 1'b1 >= olen_q) begin
						out_last <= 1'b1;
						olen_q <= '0;
						ordpos_q <= '0;
					end else begin
						out_last <= 1'b0;
						ordpos_q <= ordpos_q + 1'b1;
					end
				end else begin
					out_valid <= 1'b0;
					out_last <= 1'b0;
					out_byte <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_q <= '0;
			drop_q <= '0;
		end else begin
			if (cmd.bump_loss && loss_q != 16'hFFFF)
				loss_q <= loss_q + 1'b1;
			if (cmd.bump_drop && drop_q != 16'hFFFF)
				drop_q <= drop_q + 1'b1;
		end
	end
	assign lost_count = loss_q;
	assign dropped_count = drop_q;
endmodule

/* hw/rtl/ufr_ctrl.sv */
// Controller: sequences byte intake, table lookup, copies and drain.
module ufr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic command,
	input  logic end_of_datagram,
	output logic out_ready_hold,
	input  logic out_ready,
	input  ufr_pkg::status_t status,
	output ufr_pkg::cmd_t cmd
);
	ufr_pkg::state_t state_q, state_d;
	logic res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ufr_pkg::ST_IDLE;
			res_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q <= res_d;
		end
	end

	assign out_ready_hold = res_q;

	always_comb begin
		state_d = state_q;
		res_d = res_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ufr_pkg::ST_IDLE: begin
				in_ready = !res_q;
				if (res_q && out_ready)
					res_d = 1'b0;
				if (in_valid && !res_q) begin
					if (command == ufr_pkg::CMD_DRAIN) begin
						cmd.drain = 1'b1;
						state_d = ufr_pkg::ST_RESULT;
					end else begin
						cmd.take_byte = 1'b1;
						if (end_of_datagram) begin
							cmd.scan_start = 1'b1;
							state_d = ufr_pkg::ST_LOOKUP;
						end
					end
				end
			end
			ufr_pkg::ST_RESULT: begin
				res_d = 1'b1;
				state_d = ufr_pkg::ST_IDLE;
			end
			ufr_pkg::ST_LOOKUP: begin
				if (status.scan_done)
					state_d = ufr_pkg::ST_DECIDE;
			end
			ufr_pkg::ST_DECIDE: begin
				state_d = ufr_pkg::ST_FINISH;
				case (status.decision)
					ufr_pkg::DEC_DROP: cmd.bump_drop = 1'b1;
					ufr_pkg::DEC_DIRECT: begin
						cmd.commit_emit_direct = 1'b1;
						cmd.copy_start = 1'b1;
						cmd.copy_kind = ufr_pkg::CP_STG_TO_OUT;
						state_d = ufr_pkg::ST_COPY_STG;
					end
					ufr_pkg::DEC_ALLOC: begin
						cmd.commit_alloc = 1'b1;
						cmd.copy_start = 1'b1;
						cmd.copy_kind = ufr_pkg::CP_STG_TO_ENT;
						state_d = ufr_pkg::ST_COPY_STG;
					end
					ufr_pkg::DEC_RESTART: begin
						cmd.bump_loss = 1'b1;
						cmd.commit_restart = 1'b1;
						cmd.copy_start = 1'b1;
						cmd.copy_kind = ufr_pkg::CP_STG_TO_ENT;
						state_d = ufr_pkg::ST_COPY_STG;
					end
					ufr_pkg::DEC_APPEND: begin
						cmd.commit_append = 1'b1;
						cmd.copy_start = 1'b1;
						cmd.copy_kind = ufr_pkg::CP_STG_TO_ENT;
						state_d = ufr_pkg::ST_COPY_STG;
					end
					ufr_pkg::DEC_APPEND_EMIT: begin
						cmd.commit_append = 1'b1;
						cmd.copy_start = 1'b1;
						cmd.copy_kind = ufr_pkg::CP_STG_TO_ENT;
						state_d = ufr_pkg::ST_COPY_ENT;
					end
					default: ;
				endcase
			end
			ufr_pkg::ST_COPY_STG: begin
				if (status.copy_done)
					state_d = ufr_pkg::ST_FINISH;
			end
			ufr_pkg::ST_COPY_ENT: begin
				if (status.copy_done) begin
					cmd.copy_start = 1'b1;
					cmd.copy_kind = ufr_pkg::CP_ENT_TO_OUT;
					state_d = ufr_pkg::ST_COPY_STG;
				end
			end
			ufr_pkg::ST_FINISH: begin
				cmd.clear_header = 1'b1;
				state_d = ufr_pkg::ST_IDLE;
			end
			default: state_d = ufr_pkg::ST_IDLE;
		endcase
	end
endmodule

/* hw/rtl/ufr_checker.sv */
// Port-level checks for the reassembler, bound to the top level.
module ufr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic res_valid,
	input logic res_ready,
	input logic out_valid,
	input logic out_last,
	input logic [15:0] lost_count,
	input logic [15:0] dropped_count
);
	a_no_accept_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !in_ready) else $error("input taken with result pending");
	a_last_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_last |-> out_valid) else $error("last without valid");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid) else $error("result dropped");
	a_drop_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 dropped_count >= $past(dropped_count)) else $error("drop count fell");
	a_loss_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 lost_count >= $past(lost_count)) else $error("loss count fell");
endmodule

bind udp_fragment_reassembler ufr_checker u_chk (.*);

/* test/udp_fragment_reassembler_checker.sv */
// Checker for the UDP fragment reassembler: predicts every drain result and compares it.
module udp_fragment_reassembler_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic command,
	input  logic [7:0] data_byte,
	input  logic end_of_datagram,
	input  logic res_valid,
	input  logic res_ready,
	input  logic out_valid,
	input  logic [7:0] out_byte,
	input  logic out_last,
	input  logic [15:0] lost_count,
	input  logic [15:0] dropped_count,
	output int errors,
	output int pending
);
	localparam int HDR = 12;
	localparam int SLOTS = 8;
	localparam int MAXB = 2048;
	localparam int POS_CAP = HDR + MAXB + 1;
	localparam int EXP_DEPTH = 8;

	typedef struct packed {
		logic v;
		logic [7:0] b;
		logic l;
		logic [15:0] lost;
		logic [15:0] drop;
	} drain_result_t;

	// expected results in order, as a ring
	drain_result_t exp_ring [EXP_DEPTH];
	int wr_ptr = 0, rd_ptr = 0;

	int pos;
	logic [31:0] h_sender, h_num, h_total;
	logic [7:0] staging [MAXB];
	logic slot_used [SLOTS];
	logic [31:0] slot_sender [SLOTS];
	logic [31:0] slot_num [SLOTS];
	int slot_len [SLOTS];
	logic [7:0] slot_mem [SLOTS][MAXB];
	logic [7:0] emit_mem [MAXB];
	int emit_len, emit_rd;
	logic [15:0] losses, drops;

	assign pending = wr_ptr - rd_ptr;

	function automatic logic [15:0] sat_inc(input logic [15:0] c);
		return (c == 16'hFFFF) ? c : c + 16'd1;
	endfunction

	task automatic absorb_byte(input logic [7:0] b);
		if (pos < 4) h_sender[8*pos +: 8] = b;
		else if (pos < 8) h_num[8*(pos-4) +: 8] = b;
		else if (pos < 12) h_total[8*(pos-8) +: 8] = b;
		else if (pos - HDR < MAXB) staging[pos-HDR] = b;
		if (pos < POS_CAP) pos++;
	endtask

	task automatic close_datagram();
		int plen, slot, old, total;
		bit hit;
		hit = 0;
		slot = 0;
		if (pos <= HDR) return;
		plen = pos - HDR;
		if (plen > MAXB) begin
			drops = sat_inc(drops);
			return;
		end
		if (32'(plen) == h_total) begin
			if (emit_len != 0) begin
				drops = sat_inc(drops);
				return;
			end
			for (int i = 0; i < plen; i++) emit_mem[i] = staging[i];
			emit_len = plen;
			emit_rd = 0;
			return;
		end
		for (int i = 0; i < SLOTS; i++)
			if (!hit && slot_used[i] && slot_sender[i] == h_sender) begin
				slot = i;
				hit = 1;
			end
		if (!hit) begin
			for (int i = 0; i < SLOTS; i++)
				if (!hit && !slot_used[i]) begin
					slot = i;
					hit = 1;
				end
			if (!hit) begin
				drops = sat_inc(drops);
				return;
			end
			slot_used[slot] = 1;
			slot_sender[slot] = h_sender;
			slot_num[slot] = h_num;
			for (int i = 0; i < plen; i++) slot_mem[slot][i] = staging[i];
			slot_len[slot] = plen;
			return;
		end
		// existing entry with a new message number: abandon and restart
		if (slot_len[slot] > 0 && slot_num[slot] != h_num) begin
			losses = sat_inc(losses);
			slot_num[slot] = h_num;
			for (int i = 0; i < plen; i++) slot_mem[slot][i] = staging[i];
			slot_len[slot] = plen;
			return;
		end
		old = slot_len[slot];
		total = old + plen;
		if (total > MAXB || (32'(total) == h_total && emit_len != 0)) begin
			drops = sat_inc(drops);
			return;
		end
		slot_num[slot] = h_num;
		for (int i = 0; i < plen; i++) slot_mem[slot][old+i] = staging[i];
		slot_len[slot] = total;
		if (32'(total) == h_total) begin
			for (int i = 0; i < total; i++) emit_mem[i] = slot_mem[slot][i];
			emit_len = total;
			emit_rd = 0;
			slot_len[slot] = 0;
		end
	endtask

	function automatic drain_result_t drain_one();
		drain_result_t r;
		r = '0;
		if (emit_len != 0 && emit_rd < emit_len) begin
			r.v = 1;
			r.b = emit_mem[emit_rd];
			emit_rd++;
			if (emit_rd >= emit_len) begin
				r.l = 1;
				emit_len = 0;
				emit_rd = 0;
			end
		end
		r.lost = losses;
		r.drop = drops;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drain_result_t want;
		if (!arst_n) begin
			pos = 0;
			h_sender = '0;
			h_num = '0;
			h_total = '0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_used[i] = 0;
				slot_len[i] = 0;
			end
			emit_len = 0;
			emit_rd = 0;
			losses = '0;
			drops = '0;
			errors = 0;
			wr_ptr = 0;
			rd_ptr = 0;
		end else begin
			// compare first, so a drain accepted on the same edge is not matched early
			if (res_valid && res_ready) begin
				if (wr_ptr == rd_ptr) begin
					errors++;
					$display("%0t: result transfer with nothing expected", $time);
				end else begin
					want = exp_ring[rd_ptr % EXP_DEPTH];
					rd_ptr++;
					if (out_valid !== want.v || out_byte !== want.b || out_last !== want.l ||
					    lost_count !== want.lost || dropped_count !== want.drop) begin
						errors++;
						$display("%0t: expected v=%0b byte=%h last=%0b lost=%0d drop=%0d",
							$time, want.v, want.b, want.l, want.lost, want.drop);
						$display("%0t:   actual v=%0b byte=%h last=%0b lost=%0d drop=%0d",
							$time, out_valid, out_byte, out_last, lost_count, dropped_count);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (command == ufr_pkg::CMD_DRAIN) begin
					if (wr_ptr - rd_ptr >= EXP_DEPTH) begin
						errors++;
						$display("%0t: too many drain transfers outstanding", $time);
					end else begin
						exp_ring[wr_ptr % EXP_DEPTH] = drain_one();
						wr_ptr++;
					end
				end else begin
					absorb_byte(data_byte);
					if (end_of_datagram) begin
						close_datagram();
						pos = 0;
						h_sender = '0;
						h_num = '0;
						h_total = '0;
					end
				end
			end
		end
	end
endmodule

/* test/udp_fragment_reassembler_test.sv */
// Testbench top for the UDP fragment reassembler: stimulus, clock, reset and verdict.
module udp_fragment_reassembler_test;
	// Generous ceiling: about 1250 transfers, each datagram end followed by
	// a table scan and short buffer copies, with random idling.
	localparam int CYCLE_LIMIT = 3_000_000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic command = ufr_pkg::CMD_BYTE;
	logic [7:0] data_byte = '0;
	logic end_of_datagram = 0;
	logic res_valid;
	logic res_ready = 0;
	logic out_valid;
	logic [7:0] out_byte;
	logic out_last;
	logic [15:0] lost_count, dropped_count;

	int errors, pending;
	int cycles = 0;
	int byte_xfers = 0, drain_xfers = 0, datagrams = 0;
	bit calm = 0; // stretch with no idling on either side

	udp_fragment_reassembler i_dut (
		.clk, .arst_n, .in_valid, .in_ready, .command, .data_byte, .end_of_datagram,
		.res_valid, .res_ready, .out_valid, .out_byte, .out_last, .lost_count,
		.dropped_count
	);

	udp_fragment_reassembler_checker i_check (
		.clk, .arst_n, .in_valid, .in_ready, .command, .data_byte, .end_of_datagram,
		.res_valid, .res_ready, .out_valid, .out_byte, .out_last, .lost_count,
		.dropped_count, .errors, .pending
	);

	always #2 clk = ~clk;

	// Receiver side: stalls about 36% of cycles unless in the calm stretch.
	always @(posedge clk) begin
		res_ready <= calm || ($urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[udp_fragment_reassembler] ERROR");
			$finish;
		end
	end

	// One input transfer; idle cycles before it make up about 36% of cycles.
	task automatic put(input logic cmd, input logic [7:0] b, input logic eod);
		logic rdy;
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		data_byte <= b;
		end_of_datagram <= eod;
		// ready is sampled mid-cycle, away from the edge where it changes
		forever begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
			if (rdy) break;
		end
		if (cmd == ufr_pkg::CMD_DRAIN) drain_xfers++;
		else byte_xfers++;
	endtask

	task automatic drain(input int n);
		repeat (n) put(ufr_pkg::CMD_DRAIN, 8'($urandom), 1'($urandom));
	endtask

	// Header (little-endian sender, number, size) then plen random payload bytes.
	task automatic datagram(input logic [31:0] snd, input logic [31:0] num,
	                        input logic [31:0] total, input int plen);
		logic [95:0] hdr;
		hdr = {total, num, snd};
		datagrams++;
		for (int i = 0; i < 12; i++)
			put(ufr_pkg::CMD_BYTE, hdr[8*i +: 8], plen == 0 && i == 11);
		for (int i = 0; i < plen; i++)
			put(ufr_pkg::CMD_BYTE, 8'($urandom), i == plen - 1);
	endtask

	// Datagram cut short inside the header.
	task automatic short_datagram(input int n);
		datagrams++;
		for (int i = 0; i < n; i++) put(ufr_pkg::CMD_BYTE, 8'($urandom), i == n - 1);
	endtask

	initial begin
		logic [31:0] pool [8] = '{2, 3, 10, 11, 12, 13, 14, 15};
		int r, total, left, frag;
		logic [31:0] snd, num;

		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty drain, short and header-only datagrams.
		drain(1);
		short_datagram(5);
		datagram(32'h1, 0, 0, 0);
		// whole message, drained with one extra empty step
		datagram(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 3);
		drain(4);
		// fragments appended to a new entry and emitted
		datagram(2, 7, 4, 2);
		datagram(2, 7, 4, 2);
		drain(4);
		// busy output: second whole message dropped
		datagram(5, 0, 2, 2);
		datagram(6, 0, 2, 2);
		drain(3);
		// number change abandons partial data
		datagram(3, 1, 10, 3);
		datagram(3, 2, 10, 3);
		// fill the table, then one sender too many
		for (int i = 10; i < 16; i++) datagram(i, 0, 100, 1);
		datagram(32'h8000_0000, 0, 100, 1);

		// Random: mostly well-formed fragment sequences from known senders.
		while (byte_xfers + drain_xfers < 1220) begin
			calm = (byte_xfers + drain_xfers) inside {[500:750]};
			r = $urandom_range(99);
			if (r < 60) begin
				snd = ($urandom_range(19) == 0) ? $urandom : pool[$urandom_range(7)];
				num = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(3));
				total = $urandom_range(1, 24);
				left = total;
				while (left > 0) begin
					frag = $urandom_range(1, left);
					if ($urandom_range(9) == 0) frag = left + 1; // overshoots the size
					datagram(snd, num, total, frag);
					left -= frag;
				end
				if ($urandom_range(1)) drain($urandom_range(total + 2));
			end else if (r < 75) begin
				drain($urandom_range(1, 30));
			end else if (r < 85) begin
				total = $urandom_range(1, 16);
				datagram(pool[$urandom_range(7)], $urandom, total, total);
			end else if (r < 95) begin
				datagram($urandom, $urandom, $urandom, $urandom_range(1, 20));
			end else begin
				short_datagram($urandom_range(1, 12));
			end
		end
		calm = 0;
		drain(30);
		in_valid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d datagrams in %0d byte transfers and %0d drain transfers",
			datagrams, byte_xfers, drain_xfers);
		$display("final counters: lost %0d, dropped %0d", lost_count, dropped_count);
		if (errors == 0) begin
			$display("[udp_fragment_reassembler] OK");
		end else begin
			$display("[udp_fragment_reassembler] ERROR");
		end
		$finish;
	end
endmodule
